FILE: design/tcle_pkg.sv
// shared types and constants of the canonical line editor
package tcle_pkg;

    // request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_INTR = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_ECHO    = 3'd0;
    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_EOF     = 3'd2;
    localparam logic [2:0] KIND_INTR    = 3'd3;
    localparam logic [2:0] KIND_REFUSED = 3'd4;
    localparam logic [2:0] KIND_NOLINE  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_CANONICAL  = 3'd0;
    localparam logic [2:0] CFG_ECHO       = 3'd1;
    localparam logic [2:0] CFG_ECHO_ERASE = 3'd2;
    localparam logic [2:0] CFG_CR_TO_NL   = 3'd3;
    localparam logic [2:0] CFG_EOF_CHAR   = 3'd4;
    localparam logic [2:0] CFG_ERASE_CHAR = 3'd5;

    // control characters
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_SP = 8'd32;

    // register reset values
    localparam logic [7:0] EOF_CHAR_RESET   = 8'd4;
    localparam logic [7:0] ERASE_CHAR_RESET = 8'd127;

    typedef struct packed {
        logic       canonical_mode;
        logic       echo_enable;
        logic       echo_erase_enable;
        logic       cr_to_newline;
        logic [7:0] eof_char;
        logic [7:0] erase_char;
    } cfg_t;

endpackage

FILE: design/tcle_cfg_regs.sv
// configuration register file of the canonical line editor
module tcle_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic [2:0]      cfg_index,
    input  logic [7:0]      cfg_data,
    output tcle_pkg::cfg_t  cfg
);
    import tcle_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CANONICAL:  cfg_next.canonical_mode    = cfg_data[0];
                CFG_ECHO:       cfg_next.echo_enable       = cfg_data[0];
                CFG_ECHO_ERASE: cfg_next.echo_erase_enable = cfg_data[0];
                CFG_CR_TO_NL:   cfg_next.cr_to_newline     = cfg_data[0];
                CFG_EOF_CHAR:   cfg_next.eof_char          = cfg_data;
                CFG_ERASE_CHAR: cfg_next.erase_char        = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.canonical_mode    <= 1'b1;
            cfg_reg.echo_enable       <= 1'b1;
            cfg_reg.echo_erase_enable <= 1'b1;
            cfg_reg.cr_to_newline     <= 1'b1;
            cfg_reg.eof_char          <= EOF_CHAR_RESET;
            cfg_reg.erase_char        <= ERASE_CHAR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/tty_canonical_line_editor_top.sv
// top level of the canonical terminal line editor
//
// a request is taken when start is high and busy is low. every result appears
// on kind, out_byte and last for exactly one cycle with strobe high, starting
// the cycle after the request is taken; the receiver cannot stall it and must
// take each result as it comes. most requests give at most one result and
// leave busy low, so a new request can follow in the next cycle. an erase
// with echo gives three results (backspace, space, backspace), and a read
// gives one data byte per cycle for up to MAX_READ_BURST bytes; busy stays
// high until the last result of such a request is out. read bursts are
// paced by the line memory, a single synchronous ram with one write port
// and one registered read port, which is read once per delivered byte. the
// line memory needs no clearing after reset since only bytes stored after
// reset are ever read back. configuration writes are registered and are
// meant to be made while the block is idle.
module tty_canonical_line_editor_top #(
    parameter int LINE_CAPACITY  = 1024,
    parameter int MAX_READ_BURST = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    // request side
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [7:0] rx_byte,
    input  logic [6:0] read_count,
    // result side
    output logic       strobe,
    output logic [2:0] kind,
    output logic [7:0] out_byte,
    output logic       last,
    // configuration
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import tcle_pkg::*;

    localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W = $clog2(LINE_CAPACITY);

    localparam logic [LEN_W-1:0] CAP       = LEN_W'(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] CAP_M1    = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
    localparam logic [6:0]       BURST_MAX = 7'(MAX_READ_BURST);

    // sequencer states
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_ERASE_SP = 2'd1;
    localparam logic [1:0] ST_ERASE_BS = 2'd2;
    localparam logic [1:0] ST_READ     = 2'd3;

    cfg_t cfg;

    tcle_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // control state
    logic [1:0]       state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] rp_reg, rp_next;
    logic             ready_reg, ready_next;
    logic [6:0]       n_reg, n_next;
    logic             strobe_reg, strobe_next;

    // result payload
    logic [2:0]       kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             from_mem_reg, from_mem_next;

    // line memory
    logic [7:0]        line_mem [LINE_CAPACITY];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        rd_data_reg;

    // request decode helpers
    logic             accept;
    logic [7:0]       ch;
    logic [6:0]       sat_count;
    logic             issue;
    logic [6:0]       issue_n;
    logic [LEN_W-1:0] rp_plus;
    logic             line_end;
    logic             burst_end;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    // with cr_to_newline set, carriage return folds into newline before the canonical tests
    assign ch        = (cfg.cr_to_newline && rx_byte == CH_CR) ? CH_LF : rx_byte;
    assign sat_count = (read_count > BURST_MAX) ? BURST_MAX : read_count;
    assign rp_plus   = rp_reg + LEN_ONE;
    assign line_end  = (rp_plus >= len_reg);
    assign burst_end = (issue_n == 7'd1);

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        rp_next       = rp_reg;
        ready_next    = ready_reg;
        n_next        = n_reg;
        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        from_mem_next = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = len_reg[ADDR_W-1:0];
        mem_wdata     = ch;
        mem_raddr     = rp_reg[ADDR_W-1:0];
        issue         = 1'b0;
        issue_n       = n_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_BYTE:
                        begin
                            if (!cfg.canonical_mode)
                            begin
                                // raw mode: the byte goes straight out
                                strobe_next = 1'b1;
                                kind_next   = KIND_DATA;
                                byte_next   = rx_byte;
                                last_next   = 1'b1;
                            end
                            else if (ready_reg)
                            begin
                                // a finished line still waits to be read
                                strobe_next = 1'b1;
                                kind_next   = KIND_REFUSED;
                                byte_next   = 8'd0;
                                last_next   = 1'b1;
                            end
                            else if (ch == CH_LF)
                            begin
                                if (cfg.echo_enable)
                                begin
                                    strobe_next = 1'b1;
                                    kind_next   = KIND_ECHO;
                                    byte_next   = CH_LF;
                                    last_next   = 1'b1;
                                end
                                // newline may take the last free slot
                                if (len_reg < CAP)
                                begin
                                    mem_we   = 1'b1;
                                    len_next = len_reg + LEN_ONE;
                                end
                                ready_next = 1'b1;
                                rp_next    = '0;
                            end
                            else if (ch == cfg.eof_char)
                            begin
                                // eof ends the line; an empty line here becomes an end-of-file mark
                                ready_next = 1'b1;
                                rp_next    = '0;
                            end
                            else if (ch == cfg.erase_char || ch == CH_BS)
                            begin
                                if (len_reg != '0)
                                begin
                                    len_next = len_reg - LEN_ONE;
                                    if (cfg.echo_enable && cfg.echo_erase_enable)
                                    begin
                                        strobe_next = 1'b1;
                                        kind_next   = KIND_ECHO;
                                        byte_next   = CH_BS;
                                        last_next   = 1'b0;
                                        state_next  = ST_ERASE_SP;
                                    end
                                end
                            end
                            else if (len_reg < CAP_M1)
                            begin
                                mem_we   = 1'b1;
                                len_next = len_reg + LEN_ONE;
                                if (cfg.echo_enable)
                                begin
                                    strobe_next = 1'b1;
                                    kind_next   = KIND_ECHO;
                                    byte_next   = ch;
                                    last_next   = 1'b1;
                                end
                            end
                        end
                        REQ_READ:
                        begin
                            if (read_count != 7'd0)
                            begin
                                if (!cfg.canonical_mode || !ready_reg)
                                begin
                                    strobe_next = 1'b1;
                                    kind_next   = KIND_NOLINE;
                                    byte_next   = 8'd0;
                                    last_next   = 1'b1;
                                end
                                else if (len_reg == '0)
                                begin
                                    // consume the end-of-file mark
                                    ready_next  = 1'b0;
                                    rp_next     = '0;
                                    strobe_next = 1'b1;
                                    kind_next   = KIND_EOF;
                                    byte_next   = 8'd0;
                                    last_next   = 1'b1;
                                end
                                else
                                begin
                                    issue   = 1'b1;
                                    issue_n = sat_count;
                                end
                            end
                        end
                        REQ_INTR:
                        begin
                            // only a partial line is thrown away
                            if (!ready_reg)
                            begin
                                len_next = '0;
                                rp_next  = '0;
                            end
                            strobe_next = 1'b1;
                            kind_next   = KIND_INTR;
                            byte_next   = 8'd0;
                            last_next   = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ERASE_SP:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_ECHO;
                byte_next   = CH_SP;
                last_next   = 1'b0;
                state_next  = ST_ERASE_BS;
            end
            ST_ERASE_BS:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_ECHO;
                byte_next   = CH_BS;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_READ:
            begin
                issue   = 1'b1;
                issue_n = n_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // one data byte per cycle: the ram read issued now lands in
        // rd_data_reg in the same cycle that the result strobe is shown
        if (issue)
        begin
            strobe_next   = 1'b1;
            kind_next     = KIND_DATA;
            byte_next     = 8'd0;
            from_mem_next = 1'b1;
            last_next     = line_end || burst_end;
            n_next        = issue_n - 7'd1;
            if (line_end)
            begin
                // line used up
                ready_next = 1'b0;
                len_next   = '0;
                rp_next    = '0;
                state_next = ST_IDLE;
            end
            else
            begin
                rp_next    = rp_plus;
                state_next = burst_end ? ST_IDLE : ST_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            rp_reg     <= '0;
            ready_reg  <= 1'b0;
            n_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            rp_reg     <= rp_next;
            ready_reg  <= ready_next;
            n_reg      <= n_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        from_mem_reg <= from_mem_next;
    end

    // line memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= line_mem[mem_raddr];
    end

    assign strobe   = strobe_reg;
    assign kind     = kind_reg;
    assign out_byte = from_mem_reg ? rd_data_reg : byte_reg;
    assign last     = last_reg;

endmodule
